// File: src/gkg_pkg.sv
package gkg_pkg;

   // configuration port layout
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIGMA_Q8 = 4'd1;

   // field widths fixed by the interface
   localparam int RADIUS_W = 2;
   localparam int SIGMA_W  = 12;
   localparam int TAG_W    = 8;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 2'd1;
   localparam logic [SIGMA_W-1:0]  SIGMA_RESET  = 12'd256;

   // squared sigma in Q16 and the exponent fraction
   localparam int S2_W       = 24;
   localparam int Q_FRAC_W   = 16;
   localparam int EXP_N_W    = 5;
   localparam int EXP_N_LIMIT = 16;

   // Taylor series length and Q32 constants
   localparam int TERM_W = 4;
   localparam logic [TERM_W-1:0] EXP_TERMS = 4'd12;
   localparam int Q32_W = 33;
   localparam logic [Q32_W-1:0] ONE_Q32   = 33'h1_0000_0000;
   localparam logic [31:0]      INV_E_Q32 = 32'd1580030169;

   // shared multiplier operand widths
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 33;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// File: src/gkg_multiplier.sv
module gkg_multiplier #(
   parameter int A_W = 32,
   parameter int B_W = 33
) (
   input  logic               clock,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic [A_W+B_W-1:0] product
);

   logic [A_W+B_W-1:0] product_ff;
   logic [A_W+B_W-1:0] product_in;

   // full-width product, registered
   assign product_in = (A_W + B_W)'(a) * (A_W + B_W)'(b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// File: src/gkg_divider.sv
module gkg_divider #(
   parameter int DIVIDEND_W = 36,
   parameter int DIVISOR_W  = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DIVIDEND_W-1:0]   dividend,
   input  logic [DIVISOR_W-1:0]    divisor,
   output gkg_pkg::div_status_type status,
   output logic [DIVIDEND_W-1:0]   quotient
);

   import gkg_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // one restoring step: shift in the next dividend bit, try to subtract
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
         cnt_in     = CNT_W'(DIVIDEND_W);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// File: src/gaussian_kernel_generator.sv
// Normalized 2-D Gaussian kernel generator.
// Configure radius (index 0) and sigma_q8 (index 1) on the csr_ channel while
// the block is idle; csr_ready is always high. A transfer on the req_ channel
// starts one kernel; req_ready is high only while no kernel is being built.
// The kernel of side 2r+1 comes out on the rsp_ channel row by row, left to
// right, one transfer per weight, with rsp_last on the final weight and the
// request tag echoed on each.
// Every division goes through one shared restoring divider that takes one
// dividend bit per cycle, and the Taylor series needs twelve divisions per
// weight. The integer part n of the exponent (up to 16) costs one multiply
// by 1/e per unit; a weight whose exponent reaches the limit underflows to
// zero without the series. Each normalized weight then needs one more division.
// The result sits in an output register: a stalled receiver holds the next
// weight back, and once the last weight is loaded the block is ready for a new
// request. Reset restores radius 1 and sigma 1.0 and empties the output
// register; the raw weight store needs no clearing.
module gaussian_kernel_generator #(
   parameter int MAX_RADIUS = 3,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [gkg_pkg::TAG_W-1:0]           req_request_tag,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [FRAC_BITS:0]                  rsp_weight,
   output logic [$clog2(2*MAX_RADIUS+2)-1:0]   rsp_row,
   output logic [$clog2(2*MAX_RADIUS+2)-1:0]   rsp_column,
   output logic [gkg_pkg::TAG_W-1:0]           rsp_tag_echo,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gkg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gkg_pkg::CSR_DATA_W-1:0]      csr_data
);

   import gkg_pkg::*;

   localparam int POS_W   = $clog2(2*MAX_RADIUS + 2);
   localparam int SIDE_MAX = 2*MAX_RADIUS + 1;
   localparam int ENTRIES = SIDE_MAX * SIDE_MAX;
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int D2_MAX  = 2 * MAX_RADIUS * MAX_RADIUS;
   localparam int D2_W    = (D2_MAX > 0) ? $clog2(D2_MAX + 1) : 1;
   localparam int RAW_W   = FRAC_BITS + 1;
   localparam int SUM_W   = FRAC_BITS + 6;
   localparam int T_W     = D2_W + 31;
   localparam int N_W     = 2*FRAC_BITS + 1;
   localparam int DIV_W0  = (T_W > N_W) ? T_W : N_W;
   localparam int DIV_W   = (DIV_W0 > Q32_W) ? DIV_W0 : Q32_W;
   localparam int DVS_W   = (S2_W > SUM_W) ? S2_W : SUM_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam logic [DIV_W-1:0] T_LIMIT = DIV_W'((EXP_N_LIMIT + 1) * (2**Q_FRAC_W));
   localparam logic [Q32_W:0]   RAW_ROUND = (Q32_W + 1)'(1) << (31 - FRAC_BITS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SQUARE_WAIT,
      ST_T_DIV,
      ST_T_WAIT,
      ST_H_MUL,
      ST_H_ROUND,
      ST_H_WAIT,
      ST_N_MUL,
      ST_N_ROUND,
      ST_RAW,
      ST_STORE,
      ST_NORM_READ,
      ST_NORM_DIV,
      ST_NORM_WAIT
   } state_type;

   state_type             state_ff, state_in;
   logic [RADIUS_W-1:0]   radius_ff, radius_in;
   logic [SIGMA_W-1:0]    sigma_ff, sigma_in;
   logic [TAG_W-1:0]      tag_ff, tag_in;
   logic [S2_W-1:0]       s2_ff, s2_in;
   logic [POS_W-1:0]      x_ff, x_in;
   logic [POS_W-1:0]      y_ff, y_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [Q_FRAC_W-1:0]   xfrac_ff, xfrac_in;
   logic [EXP_N_W-1:0]    n_ff, n_in;
   logic [TERM_W-1:0]     k_ff, k_in;
   logic [Q32_W-1:0]      r_ff, r_in;
   logic [RAW_W-1:0]      raw_ff, raw_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RAW_W-1:0]      rsp_weight_ff, rsp_weight_in;
   logic [POS_W-1:0]      rsp_row_ff, rsp_row_in;
   logic [POS_W-1:0]      rsp_column_ff, rsp_column_in;
   logic [TAG_W-1:0]      rsp_tag_ff, rsp_tag_in;
   logic                  rsp_last_ff, rsp_last_in;

   // raw weight store
   logic [RAW_W-1:0]      raw_mem [ENTRIES];
   logic [RAW_W-1:0]      rd_ff;
   logic                  mem_we;

   // shared units
   logic                  div_start;
   logic [DIV_W-1:0]      div_dividend;
   logic [DVS_W-1:0]      div_divisor;
   logic [DIV_W-1:0]      div_quotient;
   div_status_type        div_status;
   logic [MUL_A_W-1:0]    mul_a;
   logic [MUL_B_W-1:0]    mul_b;
   logic [PROD_W-1:0]     mul_product;

   // derived values
   logic [SIGMA_W-1:0]    sigma_eff;
   logic [POS_W-1:0]      rad_eff;
   logic [POS_W-1:0]      side_last;
   logic [POS_W-1:0]      dx, dy;
   logic [D2_W-1:0]       dx_e, dy_e, d2;
   logic [DIV_W-1:0]      t_dividend;
   logic [48:0]           h_round;
   logic [Q32_W-1:0]      horner_p;
   logic [PROD_W-1:0]     n_round;
   logic [Q32_W:0]        raw_round;
   logic                  at_last;
   logic [POS_W-1:0]      x_next, y_next;

   gkg_divider #(
      .DIVIDEND_W(DIV_W),
      .DIVISOR_W (DVS_W)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .status  (div_status),
      .quotient(div_quotient)
   );

   gkg_multiplier #(
      .A_W(MUL_A_W),
      .B_W(MUL_B_W)
   ) u_multiplier (
      .clock  (clock),
      .a      (mul_a),
      .b      (mul_b),
      .product(mul_product)
   );

   // zero sigma acts as the narrowest one, radius clamps to the build limit
   assign sigma_eff = (sigma_ff == '0) ? SIGMA_W'(1) : sigma_ff;
   assign rad_eff   = (int'(radius_ff) > MAX_RADIUS) ? POS_W'(MAX_RADIUS) : POS_W'(radius_ff);
   assign side_last = POS_W'({rad_eff, 1'b0});

   // squared distance from the center
   assign dx   = (x_ff > rad_eff) ? x_ff - rad_eff : rad_eff - x_ff;
   assign dy   = (y_ff > rad_eff) ? y_ff - rad_eff : rad_eff - y_ff;
   assign dx_e = D2_W'(dx);
   assign dy_e = D2_W'(dy);
   assign d2   = dx_e * dx_e + dy_e * dy_e;

   // exponent numerator: d2 * 2^31 plus half of s^2 for rounding
   assign t_dividend = (DIV_W'(d2) << 31) + DIV_W'(s2_ff[S2_W-1:1]);

   // rounding of the Horner product and of the 1/e product
   assign h_round   = {1'b0, mul_product[47:0]} + 49'h8000;
   assign horner_p  = h_round[48:16];
   assign n_round   = mul_product + PROD_W'(33'h0_8000_0000);
   assign raw_round = {1'b0, r_ff} + RAW_ROUND;

   // kernel scan position
   assign at_last = (x_ff == side_last) && (y_ff == side_last);
   assign x_next  = (x_ff == side_last) ? '0 : x_ff + POS_W'(1);
   assign y_next  = (x_ff == side_last) ? y_ff + POS_W'(1) : y_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      radius_in     = radius_ff;
      sigma_in      = sigma_ff;
      tag_in        = tag_ff;
      s2_in         = s2_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      addr_in       = addr_ff;
      sum_in        = sum_ff;
      xfrac_in      = xfrac_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      r_in          = r_ff;
      raw_in        = raw_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_column_in = rsp_column_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_last_in   = rsp_last_ff;
      div_start     = 1'b0;
      div_dividend  = '0;
      div_divisor   = '0;
      mul_a         = '0;
      mul_b         = '0;
      mem_we        = 1'b0;

      // register writes
      if (csr_valid) begin
         case (csr_index)
            CSR_RADIUS:   radius_in = csr_data[RADIUS_W-1:0];
            CSR_SIGMA_Q8: sigma_in  = csr_data[SIGMA_W-1:0];
            default:      ;
         endcase
      end

      // output register empties on transfer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               tag_in   = req_request_tag;
               x_in     = '0;
               y_in     = '0;
               addr_in  = '0;
               sum_in   = '0;
               state_in = ST_SQUARE;
            end
         end
         // s^2 once per kernel
         ST_SQUARE: begin
            mul_a    = MUL_A_W'(sigma_eff);
            mul_b    = MUL_B_W'(sigma_eff);
            state_in = ST_SQUARE_WAIT;
         end
         ST_SQUARE_WAIT: begin
            s2_in    = mul_product[S2_W-1:0];
            state_in = ST_T_DIV;
         end
         // exponent t in Q16
         ST_T_DIV: begin
            div_start    = 1'b1;
            div_dividend = t_dividend;
            div_divisor  = DVS_W'(s2_ff);
            state_in     = ST_T_WAIT;
         end
         ST_T_WAIT: begin
            if (div_status.done) begin
               if (div_quotient >= T_LIMIT) begin
                  raw_in   = '0;
                  state_in = ST_STORE;
               end else begin
                  xfrac_in = div_quotient[Q_FRAC_W-1:0];
                  n_in     = div_quotient[Q_FRAC_W +: EXP_N_W];
                  k_in     = EXP_TERMS;
                  r_in     = ONE_Q32;
                  state_in = ST_H_MUL;
               end
            end
         end
         // Horner step: r = 1 - round(round(x*r) / k)
         ST_H_MUL: begin
            mul_a    = MUL_A_W'(xfrac_ff);
            mul_b    = r_ff;
            state_in = ST_H_ROUND;
         end
         ST_H_ROUND: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(horner_p) + DIV_W'(k_ff >> 1);
            div_divisor  = DVS_W'(k_ff);
            state_in     = ST_H_WAIT;
         end
         ST_H_WAIT: begin
            if (div_status.done) begin
               r_in = ONE_Q32 - div_quotient[Q32_W-1:0];
               if (k_ff == TERM_W'(1)) begin
                  state_in = ST_N_MUL;
               end else begin
                  k_in     = k_ff - TERM_W'(1);
                  state_in = ST_H_MUL;
               end
            end
         end
         // integer part: one multiply by 1/e per unit
         ST_N_MUL: begin
            if (n_ff == '0) begin
               state_in = ST_RAW;
            end else begin
               mul_a    = INV_E_Q32;
               mul_b    = r_ff;
               state_in = ST_N_ROUND;
            end
         end
         ST_N_ROUND: begin
            r_in     = n_round[PROD_W-1:32];
            n_in     = n_ff - EXP_N_W'(1);
            state_in = ST_N_MUL;
         end
         ST_RAW: begin
            raw_in   = raw_round[32:32-FRAC_BITS];
            state_in = ST_STORE;
         end
         // keep the raw weight and accumulate the sum
         ST_STORE: begin
            mem_we = 1'b1;
            sum_in = sum_ff + SUM_W'(raw_ff);
            if (at_last) begin
               x_in     = '0;
               y_in     = '0;
               addr_in  = '0;
               state_in = ST_NORM_READ;
            end else begin
               x_in     = x_next;
               y_in     = y_next;
               addr_in  = addr_ff + ADDR_W'(1);
               state_in = ST_T_DIV;
            end
         end
         // normalization pass
         ST_NORM_READ: begin
            state_in = ST_NORM_DIV;
         end
         ST_NORM_DIV: begin
            div_start    = 1'b1;
            div_dividend = (DIV_W'(rd_ff) << FRAC_BITS) + DIV_W'(sum_ff >> 1);
            div_divisor  = DVS_W'(sum_ff);
            state_in     = ST_NORM_WAIT;
         end
         ST_NORM_WAIT: begin
            if (!div_status.busy && (!rsp_valid_ff || rsp_ready)) begin
               rsp_valid_in  = 1'b1;
               rsp_weight_in = div_quotient[RAW_W-1:0];
               rsp_row_in    = y_ff;
               rsp_column_in = x_ff;
               rsp_tag_in    = tag_ff;
               rsp_last_in   = at_last;
               if (at_last) begin
                  state_in = ST_IDLE;
               end else begin
                  x_in     = x_next;
                  y_in     = y_next;
                  addr_in  = addr_ff + ADDR_W'(1);
                  state_in = ST_NORM_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= RADIUS_RESET;
         sigma_ff     <= SIGMA_RESET;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         sigma_ff     <= sigma_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tag_ff        <= tag_in;
      s2_ff         <= s2_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      addr_ff       <= addr_in;
      xfrac_ff      <= xfrac_in;
      n_ff          <= n_in;
      k_ff          <= k_in;
      r_ff          <= r_in;
      raw_ff        <= raw_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_column_ff <= rsp_column_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // raw weight store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         raw_mem[addr_ff] <= raw_ff;
      end
      rd_ff <= raw_mem[addr_ff];
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_weight   = rsp_weight_ff;
   assign rsp_row      = rsp_row_ff;
   assign rsp_column   = rsp_column_ff;
   assign rsp_tag_echo = rsp_tag_ff;
   assign rsp_last     = rsp_last_ff;

   // divider is never restarted mid-division
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   // a new request never finds the divider at work
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_status.busy)
      else $error("request accepted while divider busy");

   // normalization always divides by a nonzero sum
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NORM_DIV) |-> (sum_ff != '0))
      else $error("normalization with zero weight sum");

   // done pulse marks the end of a busy stretch
   assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (!div_status.busy && $past(div_status.busy)))
      else $error("divider done without a finished division");

endmodule
